/* rtl/ftoa_pkg.sv */
// ----------------------------------------------------------------------------
// ftoa_pkg: shared types and constants for float to decimal text
// Field widths, exponent limits, character codes, queue word and back-end
// state encoding.
// ----------------------------------------------------------------------------
package ftoa_pkg;

  localparam int MAX_DECIMALS = 8;

  localparam int FLOAT_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int CFG_W      = 4;
  localparam int SIG_W      = 24;
  localparam int FRAC_W     = 24;
  localparam int IPART_W    = 31;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CNT_W      = $clog2(IPART_W);
  localparam int DCNT_W     = $clog2(BCD_DIGITS);

  // fraction digit count; must also hold the two digits of the zero text
  localparam int PLACES_W = $clog2(((MAX_DECIMALS > 2) ? MAX_DECIMALS : 2) + 1);

  // fixed-point alignment: significand shifted by (exp - 82), binary point
  // ends up between bit 68 and bit 67, fraction kept as 24 bits below it
  localparam int FIX_W        = 99;
  localparam int FIX_FRAC_LSB = 44;
  localparam int SHAMT_W      = 7;

  localparam logic [7:0] EXP_MIN    = 8'd104;  // unbiased -23
  localparam logic [7:0] EXP_MAX    = 8'd157;  // unbiased 30
  localparam logic [7:0] SHIFT_BIAS = 8'd82;

  localparam logic [CFG_W-1:0]    DP_RESET    = 4'd2;
  localparam logic [PLACES_W-1:0] ZERO_PLACES = PLACES_W'(2);
  localparam logic [PLACES_W-1:0] FLAT_PLACES = PLACES_W'(1);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ERR   = 8'h00;

  localparam int Q_DEPTH = 2;  // power of two, pointers wrap
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic                err;
    logic [IPART_W-1:0]  ipart;
    logic [FRAC_W-1:0]   frac;
    logic [PLACES_W-1:0] places;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_INT,
    B_POINT,
    B_FRAC,
    B_ERR
  } back_state_t;

endpackage

/* rtl/ftoa_front.sv */
// ----------------------------------------------------------------------------
// ftoa_front: input side
// Holds the decimal places register, accepts float words, classifies them
// (zero, out of range, normal) and aligns integer and fraction parts.
// ----------------------------------------------------------------------------
module ftoa_front import ftoa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FLOAT_W-1:0] in_float_bits,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  q_status_t          q_status,
  output logic               q_push,
  output job_t               q_job
);

  logic [CFG_W-1:0]    dp_r;
  logic [7:0]          exp8;
  logic                mag_zero;
  logic [SIG_W-1:0]    sig;
  logic [SHAMT_W-1:0]  shamt;
  logic [FIX_W-1:0]    fix;
  logic [IPART_W-1:0]  ipart;
  logic [FRAC_W-1:0]   frac;
  logic [PLACES_W-1:0] sat_places;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r <= DP_RESET;
    end else if (cfg_we) begin
      dp_r <= cfg_wdata;
    end
  end

  always_comb begin
    exp8     = in_float_bits[30:23];
    mag_zero = (in_float_bits[30:0] == 31'd0);
    sig      = {1'b1, in_float_bits[22:0]};
    shamt    = SHAMT_W'(exp8 - SHIFT_BIAS);
    fix      = FIX_W'(sig) << shamt;
    ipart    = fix[FIX_W-1 -: IPART_W];
    frac     = fix[FIX_FRAC_LSB +: FRAC_W];

    if (32'(dp_r) > MAX_DECIMALS) begin
      sat_places = PLACES_W'(MAX_DECIMALS);
    end else begin
      sat_places = PLACES_W'(dp_r);
    end

    q_job.err    = 1'b0;
    q_job.ipart  = ipart;
    q_job.frac   = frac;
    q_job.places = (frac == '0) ? FLAT_PLACES : sat_places;
    if (mag_zero) begin
      // "0.00": two zero fraction digits whatever the register holds
      q_job.ipart  = '0;
      q_job.frac   = '0;
      q_job.places = ZERO_PLACES;
    end else if (exp8 < EXP_MIN || exp8 > EXP_MAX) begin
      q_job.err = 1'b1;
    end
  end

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

endmodule

/* rtl/ftoa_queue.sv */
// ----------------------------------------------------------------------------
// ftoa_queue: job queue
// Short register FIFO between front and back end.
// ----------------------------------------------------------------------------
module ftoa_queue import ftoa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      job_in,
  input  logic      pop,
  output job_t      job_out,
  output q_status_t status
);

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt;
  logic [Q_AW-1:0] rp_r, rp_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + Q_CW'(push) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= job_in;
    end
  end

  assign job_out          = mem_r[rp_r];
  assign status.not_empty = (cnt_r != '0);
  assign status.full      = (cnt_r == Q_CW'(Q_DEPTH));

endmodule

/* rtl/ftoa_back.sv */
// ----------------------------------------------------------------------------
// ftoa_back: character sequencer
// Converts the integer part to BCD by shift-add-3, then emits integer digits,
// point and fraction digits, or an error word, through the output register.
// ----------------------------------------------------------------------------
module ftoa_back import ftoa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_status_t         q_status,
  input  job_t              q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last_char,
  output logic              out_range_error
);

  back_state_t         state_r, state_nxt;
  logic [IPART_W-1:0]  ipart_r, ipart_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic [PLACES_W-1:0] places_r, places_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                started_r, started_nxt;
  logic                ov_r, ov_nxt;
  logic [CHAR_W-1:0]   och_r, och_nxt;
  logic                olast_r, olast_nxt;
  logic                oerr_r, oerr_nxt;

  logic                can_emit;
  logic [3:0]          cur;
  logic                last_digit;
  logic                skip;
  logic [BCD_W-1:0]    bcd_adj;
  logic [FRAC_W+3:0]   prod;

  assign can_emit   = !ov_r || !out_stall;
  assign cur        = bcd_r[BCD_W-1 -: 4];
  assign last_digit = (dcnt_r == DCNT_W'(BCD_DIGITS - 1));
  assign skip       = !started_r && (cur == 4'd0) && !last_digit;
  assign prod       = ((FRAC_W+4)'(frac_r) << 3) + ((FRAC_W+4)'(frac_r) << 1);

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_status.not_empty) begin
          state_nxt = q_job.err ? B_ERR : B_CONV;
        end
      end
      B_CONV: begin
        if (cnt_r == CNT_W'(IPART_W - 1)) begin
          state_nxt = B_INT;
        end
      end
      B_INT: begin
        if (!skip && can_emit && last_digit) begin
          state_nxt = B_POINT;
        end
      end
      B_POINT: begin
        if (can_emit) begin
          state_nxt = (places_r == '0) ? B_IDLE : B_FRAC;
        end
      end
      B_FRAC: begin
        if (can_emit && places_r == PLACES_W'(1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_ERR: begin
        if (can_emit) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and output word
  always_comb begin
    q_pop       = 1'b0;
    ipart_nxt   = ipart_r;
    bcd_nxt     = bcd_r;
    frac_nxt    = frac_r;
    places_nxt  = places_r;
    cnt_nxt     = cnt_r;
    dcnt_nxt    = dcnt_r;
    started_nxt = started_r;
    ov_nxt      = ov_r && out_stall;
    och_nxt     = och_r;
    olast_nxt   = olast_r;
    oerr_nxt    = oerr_r;
    case (state_r)
      B_IDLE: begin
        if (q_status.not_empty) begin
          q_pop       = 1'b1;
          ipart_nxt   = q_job.ipart;
          frac_nxt    = q_job.frac;
          places_nxt  = q_job.places;
          bcd_nxt     = '0;
          cnt_nxt     = '0;
          dcnt_nxt    = '0;
          started_nxt = 1'b0;
        end
      end
      B_CONV: begin
        bcd_nxt   = {bcd_adj[BCD_W-2:0], ipart_r[IPART_W-1]};
        ipart_nxt = ipart_r << 1;
        cnt_nxt   = cnt_r + 1'b1;
      end
      B_INT: begin
        // leading zeros are dropped, a lone zero digit is still printed
        if (skip) begin
          bcd_nxt  = bcd_r << 4;
          dcnt_nxt = dcnt_r + 1'b1;
        end else if (can_emit) begin
          ov_nxt      = 1'b1;
          och_nxt     = CH_ZERO + CHAR_W'(cur);
          olast_nxt   = 1'b0;
          oerr_nxt    = 1'b0;
          started_nxt = 1'b1;
          bcd_nxt     = bcd_r << 4;
          dcnt_nxt    = dcnt_r + 1'b1;
        end
      end
      B_POINT: begin
        if (can_emit) begin
          ov_nxt    = 1'b1;
          och_nxt   = CH_POINT;
          olast_nxt = (places_r == '0);
          oerr_nxt  = 1'b0;
        end
      end
      B_FRAC: begin
        if (can_emit) begin
          ov_nxt     = 1'b1;
          och_nxt    = CH_ZERO + CHAR_W'(prod[FRAC_W+3 -: 4]);
          olast_nxt  = (places_r == PLACES_W'(1));
          oerr_nxt   = 1'b0;
          frac_nxt   = prod[FRAC_W-1:0];
          places_nxt = places_r - 1'b1;
        end
      end
      B_ERR: begin
        if (can_emit) begin
          ov_nxt    = 1'b1;
          och_nxt   = CH_ERR;
          olast_nxt = 1'b1;
          oerr_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      ov_r      <= 1'b0;
      started_r <= 1'b0;
      cnt_r     <= '0;
      dcnt_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      ov_r      <= ov_nxt;
      started_r <= started_nxt;
      cnt_r     <= cnt_nxt;
      dcnt_r    <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ipart_r  <= ipart_nxt;
    bcd_r    <= bcd_nxt;
    frac_r   <= frac_nxt;
    places_r <= places_nxt;
    och_r    <= och_nxt;
    olast_r  <= olast_nxt;
    oerr_r   <= oerr_nxt;
  end

  assign out_valid       = ov_r;
  assign out_char        = och_r;
  assign out_last_char   = olast_r;
  assign out_range_error = oerr_r;

endmodule

/* rtl/float_to_decimal_ascii.sv */
// Flow: an accepted word is written into the queue; when idle, the back end
//   takes it, converts the integer part to BCD bit-serially, then scans every
//   BCD digit position, leading zeros included, before point and fraction.
// Queueing: words are accepted while the back end is busy until the queue is
//   full; the back end handles one word at a time, range errors without BCD.
// Reset: synchronous, active low; clears queue and sequencer, decimal places 2.
// ----------------------------------------------------------------------------
// float_to_decimal_ascii: single-precision float to decimal text
// Front end classifies and aligns, a two-word queue decouples it from the
// back end, which streams one ASCII character per output word.
// ----------------------------------------------------------------------------
module float_to_decimal_ascii import ftoa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FLOAT_W-1:0] in_float_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_char,
  output logic               out_last_char,
  output logic               out_range_error,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  job_t      job_in;
  job_t      job_out;

  ftoa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_float_bits(in_float_bits),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_job        (job_in)
  );

  ftoa_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .job_in (job_in),
    .pop    (q_pop),
    .job_out(job_out),
    .status (q_status)
  );

  ftoa_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .q_job          (job_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_last_char  (out_last_char),
    .out_range_error(out_range_error)
  );

endmodule

/* rtl/ftoa_checker.sv */
// ----------------------------------------------------------------------------
// ftoa_checker: port-level checks
// Output word stability, error word form, character set and reset behaviour.
// ----------------------------------------------------------------------------
module ftoa_checker import ftoa_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CHAR_W-1:0]  out_char,
  input logic               out_last_char,
  input logic               out_range_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char)
      && $stable(out_last_char) && $stable(out_range_error))
    else $error("stalled output word changed");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_last_char && out_char == CH_ERR)
    else $error("malformed range error word");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |->
      (out_char >= CH_ZERO && out_char <= 8'h39) || out_char == CH_POINT)
    else $error("character outside digits and point");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid after reset");

endmodule

bind float_to_decimal_ascii ftoa_checker u_ftoa_checker (.*);
